[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Clock is clk, reset is rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check a property while out of reset
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/esc_pkg.sv]
`default_nettype none

package esc_pkg;

  localparam int SEC_W  = 32;
  localparam int DAYS_W = 16;
  localparam int TOD_W  = 17;
  localparam int YEAR_W = 12;

  localparam logic [TOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;

  // 86400 = 128 * 675: drop the low 7 bits, then divide by 675 by reciprocal
  localparam int SEC_LO_W    = 7;
  localparam int SEC_HI_W    = SEC_W - SEC_LO_W;
  localparam int DAY_REM_W   = 10;
  localparam int RECIP_W     = 26;
  localparam int DAY_PROD_W  = SEC_HI_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0]  RECIP_DAY    = 26'd50903317;
  localparam logic [SEC_HI_W-1:0] DAY_OVER_128 = 25'd675;

  // days / 7 by reciprocal, exact for any 16-bit day count
  localparam int WEEK_RECIP_W = 17;
  localparam int WEEK_PROD_W  = DAYS_W + WEEK_RECIP_W;
  localparam int WEEK_SHIFT   = 19;
  localparam logic [WEEK_RECIP_W-1:0] RECIP_WEEK = 17'd74899;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
  localparam logic [6:0]        EPOCH_Y100 = 7'd70;
  localparam logic [8:0]        EPOCH_Y400 = 9'd370;
  localparam logic [6:0]        Y100_LAST  = 7'd99;
  localparam logic [8:0]        Y400_LAST  = 9'd399;

  localparam logic [DAYS_W-1:0] DAYS_COMMON = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_LEAP   = 16'd366;

  localparam logic [3:0] MONTH_JAN  = 4'd0;
  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  localparam logic [4:0] DIV_LAST_STEP = 5'd2;

  localparam logic [3:0] DAYS_PER_WEEK = 4'd7;
  localparam logic [3:0] WDAY_OFFSET   = 4'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CAL,
    S_LOAD
  } esc_state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic cal_step;
    logic load_out;
  } esc_cmd_t;

  typedef struct packed {
    logic cal_done;
  } esc_sts_t;

  // month length by zero-based month index
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/esc_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module esc_ctrl
  import esc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output esc_cmd_t      cmd_o,
  input  wire esc_sts_t sts_i
);

  esc_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    // drop the held word once taken
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.start = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_nxt        = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST_STEP) begin
          state_nxt = S_CAL;
        end
      end
      S_CAL: begin
        cmd_o.cal_step = 1'b1;
        if (sts_i.cal_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.load_out = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `ASSERT_RST(a_accept_starts_div, (in_valid && !in_stall) |=> (state_r == S_DIV), "accepted word did not start division")
  `ASSERT_RST(a_div_length, (state_r == S_DIV && cnt_r == DIV_LAST_STEP) |=> (state_r == S_CAL), "division did not end after three steps")
  `ASSERT_RST(a_out_from_load, $rose(out_valid_r) |-> ($past(state_r) == S_LOAD), "result raised outside load")

endmodule

`default_nettype wire

[hw/rtl/esc_dp.sv]
`default_nettype none

`include "assert_macros.svh"

module esc_dp
  import esc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [SEC_W-1:0] in_seconds,
  input  wire esc_cmd_t         cmd_i,
  output esc_sts_t              sts_o,
  output logic [11:0]           out_year,
  output logic [3:0]            out_month,
  output logic [4:0]            out_day,
  output logic [4:0]            out_hour,
  output logic [5:0]            out_minute,
  output logic [5:0]            out_second,
  output logic [2:0]            out_weekday
);

  logic [SEC_W-1:0]  sec_r;
  logic [TOD_W-1:0]  tod_r;
  logic [DAYS_W-1:0] days_r;
  logic [2:0]        q7_r;
  logic [2:0]        d7_r;
  logic [YEAR_W-1:0] year_r;
  logic [6:0]        y100_r;
  logic [8:0]        y400_r;
  logic [3:0]        mon_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic              ydone_r, mdone_r, tdone_r;

  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r, out_hour_r;
  logic [5:0]  out_minute_r, out_second_r;
  logic [2:0]  out_weekday_r;

  // split off whole days by reciprocal multiplication; each step settles one more register
  logic [SEC_HI_W-1:0]  sec_hi;
  logic [DAYS_W-1:0]    days_div;
  logic [SEC_HI_W-1:0]  day_back;
  logic [DAY_REM_W-1:0] hi_rem;
  logic [2:0]           q7_div;
  logic [2:0]           d7_nxt;

  assign sec_hi   = sec_r[SEC_W-1:SEC_LO_W];
  assign days_div = DAYS_W'((DAY_PROD_W'(sec_hi) * DAY_PROD_W'(RECIP_DAY)) >> RECIP_SHIFT);
  assign day_back = SEC_HI_W'(days_r) * DAY_OVER_128;
  assign hi_rem   = DAY_REM_W'(sec_hi - day_back);
  assign q7_div   = 3'((WEEK_PROD_W'(days_r) * WEEK_PROD_W'(RECIP_WEEK)) >> WEEK_SHIFT);
  // days - 7q lies in 0..6, and -7 is 1 in three bits
  assign d7_nxt   = days_r[2:0] + q7_r;

  logic              leap;
  logic [DAYS_W-1:0] ylen, mlen;
  logic              year_fits, month_fits;

  assign leap       = ((year_r[1:0] == 2'd0) && (y100_r != 7'd0)) || (y400_r == 9'd0);
  assign ylen       = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen       = DAYS_W'(month_days(mon_r, leap));
  assign year_fits  = (days_r >= ylen);
  assign month_fits = (mon_r != MONTH_LAST) && (days_r >= mlen);

  logic [3:0] wd_sum;
  logic [2:0] wd;

  assign wd_sum = {1'b0, d7_r} + WDAY_OFFSET;
  assign wd     = (wd_sum > DAYS_PER_WEEK) ? 3'(wd_sum - DAYS_PER_WEEK) : wd_sum[2:0];

  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      sec_r    <= in_seconds;
      tod_r    <= '0;
      days_r   <= '0;
      q7_r     <= '0;
      d7_r     <= '0;
      year_r   <= EPOCH_YEAR;
      y100_r   <= EPOCH_Y100;
      y400_r   <= EPOCH_Y400;
      mon_r    <= MONTH_JAN;
      hour_r   <= '0;
      minute_r <= '0;
      ydone_r  <= 1'b0;
      mdone_r  <= 1'b0;
      tdone_r  <= 1'b0;
    end else if (cmd_i.div_step) begin
      days_r <= days_div;
      tod_r  <= {hi_rem, sec_r[SEC_LO_W-1:0]};
      q7_r   <= q7_div;
      d7_r   <= d7_nxt;
    end else if (cmd_i.cal_step) begin
      // walk whole years, then whole months
      if (!ydone_r) begin
        if (year_fits) begin
          days_r <= days_r - ylen;
          year_r <= year_r + 12'd1;
          y100_r <= (y100_r == Y100_LAST) ? 7'd0 : y100_r + 7'd1;
          y400_r <= (y400_r == Y400_LAST) ? 9'd0 : y400_r + 9'd1;
        end else begin
          ydone_r <= 1'b1;
        end
      end else if (!mdone_r) begin
        if (month_fits) begin
          days_r <= days_r - mlen;
          mon_r  <= mon_r + 4'd1;
        end else begin
          mdone_r <= 1'b1;
        end
      end
      // peel hours, then minutes, off the time of day
      if (!tdone_r) begin
        if (tod_r >= SECS_PER_HOUR) begin
          tod_r  <= tod_r - SECS_PER_HOUR;
          hour_r <= hour_r + 5'd1;
        end else if (tod_r >= SECS_PER_MIN) begin
          tod_r    <= tod_r - SECS_PER_MIN;
          minute_r <= minute_r + 6'd1;
        end else begin
          tdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_year_r    <= year_r;
      out_month_r   <= mon_r + 4'd1;
      out_day_r     <= days_r[4:0] + 5'd1;
      out_hour_r    <= hour_r;
      out_minute_r  <= minute_r;
      out_second_r  <= tod_r[5:0];
      out_weekday_r <= wd;
    end
  end

  assign sts_o.cal_done = mdone_r & tdone_r;

  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign out_hour    = out_hour_r;
  assign out_minute  = out_minute_r;
  assign out_second  = out_second_r;
  assign out_weekday = out_weekday_r;

  `ASSERT_RST(a_tod_bounded, cmd_i.cal_step |-> (tod_r < SECS_PER_DAY), "time of day out of range")
  `ASSERT_RST(a_load_when_done, cmd_i.load_out |-> (mdone_r && tdone_r && ydone_r), "result loaded before walk finished")
  `ASSERT_RST(a_month_in_year, (cmd_i.cal_step && mdone_r) |-> (mon_r <= MONTH_LAST && days_r < 16'd31), "month walk left too many days")

endmodule

`default_nettype wire

[hw/rtl/epoch_seconds_to_calendar_top.sv]
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into Gregorian
// year, month, day, hour, minute, second and weekday (1 = Monday .. 7 = Sunday).
// One word is worked at a time: a division phase splits the count into days and time
// of day by reciprocal multiplication and finds the day count mod 7, then a
// calendar walk takes one year or one month per cycle (up to 136 years and 11
// months, plus a closing step for each) while hours and minutes are peeled off the
// time of day alongside (up to 82 steps). The spacing of accepted words is set by
// the longer of the two walks: shortest at 1970-01-01 midnight, longest for dates
// late in 2105. The result sits in an output register, so the next word is taken
// while a finished result still waits on out_stall; a second result then holds
// the block until the first is taken.
`default_nettype none

module epoch_seconds_to_calendar_top
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday
);

  esc_cmd_t cmd;
  esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  esc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_seconds  (in_seconds),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .out_hour    (out_hour),
    .out_minute  (out_minute),
    .out_second  (out_second),
    .out_weekday (out_weekday)
  );

endmodule

`default_nettype wire

[dv/epoch_seconds_to_calendar_checker.sv]
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_checker
  import esc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [SEC_W-1:0]  in_seconds,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [YEAR_W-1:0] out_year,
  input  logic [3:0]        out_month,
  input  logic [4:0]        out_day,
  input  logic [4:0]        out_hour,
  input  logic [5:0]        out_minute,
  input  logic [5:0]        out_second,
  input  logic [2:0]        out_weekday,
  output int                mismatches,
  output int                pending_words,
  output int                words_checked
);

  typedef struct packed {
    logic [SEC_W-1:0]  secs;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [2:0]        weekday;
  } calendar_t;

  calendar_t due_q [$];
  calendar_t want;
  int        errs = 0;
  int        checked = 0;

  function automatic bit is_leap_yr(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
  endfunction

  // mon is zero based
  function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
    int unsigned len;
    case (mon)
      1: begin
        len = is_leap_yr(yr) ? 29 : 28;
      end
      3, 5, 8, 10: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    return len;
  endfunction

  function automatic calendar_t to_calendar(input logic [SEC_W-1:0] s);
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned rem;
    int unsigned mon;
    calendar_t   c;
    days = s / 86400;
    tod  = s % 86400;
    yr   = EPOCH_YEAR;
    rem  = days;
    mon  = 0;
    while (rem >= (is_leap_yr(yr) ? 366 : 365)) begin
      rem -= is_leap_yr(yr) ? 366 : 365;
      yr++;
    end
    while (mon < 11 && rem >= month_length(mon, yr)) begin
      rem -= month_length(mon, yr);
      mon++;
    end
    c.secs    = s;
    c.year    = YEAR_W'(yr);
    c.month   = 4'(mon + 1);
    c.day     = 5'(rem + 1);
    c.hour    = 5'(tod / 3600);
    c.minute  = 6'((tod % 3600) / 60);
    c.second  = 6'(tod % 60);
    // the epoch day was a Thursday
    c.weekday = 3'(((days + 3) % 7) + 1);
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // retire before queueing so a stray result never pairs with this edge's word
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                     out_year, out_month, out_day, out_hour, out_minute, out_second,
                     out_weekday);
          end
        end else begin
          want = due_q.pop_front();
          checked++;
          if (out_year !== want.year || out_month !== want.month || out_day !== want.day ||
              out_hour !== want.hour || out_minute !== want.minute ||
              out_second !== want.second || out_weekday !== want.weekday) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: seconds %0d expected %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                       want.secs, want.year, want.month, want.day, want.hour, want.minute,
                       want.second, want.weekday);
              $display("%0t: got %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                       out_year, out_month, out_day, out_hour, out_minute, out_second,
                       out_weekday);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        due_q.push_back(to_calendar(in_seconds));
      end
    end
    mismatches    <= errs;
    pending_words <= due_q.size();
    words_checked <= checked;
  end

endmodule

[dv/epoch_seconds_to_calendar_top_tb.sv]
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_top_tb;
  import esc_pkg::*;

  localparam int HOLD_CYCLES = 1000;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SEC_W-1:0]  in_seconds = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [YEAR_W-1:0] out_year;
  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [4:0]        out_hour;
  logic [5:0]        out_minute;
  logic [5:0]        out_second;
  logic [2:0]        out_weekday;

  int mismatches;
  int pending_words;
  int words_checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  epoch_seconds_to_calendar_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_seconds  (in_seconds),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_year    (out_year),
    .out_month   (out_month),
    .out_day     (out_day),
    .out_hour    (out_hour),
    .out_minute  (out_minute),
    .out_second  (out_second),
    .out_weekday (out_weekday)
  );

  epoch_seconds_to_calendar_checker calendar_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_seconds    (in_seconds),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_hour      (out_hour),
    .out_minute    (out_minute),
    .out_second    (out_second),
    .out_weekday   (out_weekday),
    .mismatches    (mismatches),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  // receiver: random stall, or a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("epoch_seconds_to_calendar_top regression: fail");
      $finish;
    end
  end

  function automatic logic [SEC_W-1:0] pick_seconds();
    longint yr;
    longint jan1;
    longint s;
    yr = $urandom_range(2105, 1971);
    // day number of January 1st of yr, counted from the epoch
    jan1 = (yr - 1970) * 365 + ((yr - 1) / 4 - 492) - ((yr - 1) / 100 - 19)
           + ((yr - 1) / 400 - 4);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        s = $urandom;
      end
      4: begin
        s = $urandom_range(40_000_000);
      end
      5: begin
        s = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
      end
      6: begin
        s = longint'($urandom_range(49709)) * 86400
            + ($urandom_range(1) ? $urandom_range(3) : $urandom_range(86399, 86396));
      end
      7: begin
        s = jan1 * 86400 + $urandom_range(4) - 2;
      end
      default: begin
        // late February into early March, both leap and common years
        s = (jan1 + $urandom_range(60, 57)) * 86400 + $urandom_range(86399);
      end
    endcase
    return SEC_W'(s);
  endfunction

  task automatic offer_word(input logic [SEC_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_seconds <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_set);
    send_idle_pct = idle_pct;
    stall_pct    <= stall_set;
    repeat (count) offer_word(pick_seconds());
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calendar landmarks: epoch, top of range, minute/hour/day/year turns, leap Februaries
    offer_word(32'd0);
    offer_word(32'hFFFF_FFFF);
    offer_word(32'd1);
    offer_word(32'd59);
    offer_word(32'd60);
    offer_word(32'd3599);
    offer_word(32'd3600);
    offer_word(32'd86399);
    offer_word(32'd86400);
    offer_word(32'd31535999);
    offer_word(32'd31536000);
    offer_word(32'd68083200);
    offer_word(32'd68169600);
    offer_word(32'd68256000);
    offer_word(32'd946684799);
    offer_word(32'd951782400);
    offer_word(32'd951868800);
    offer_word(32'd4102444799);
    offer_word(32'd4107456000);
    offer_word(32'd4107542400);
    offer_word(32'h8000_0000);
    offer_word(32'h7FFF_FFFF);
    offer_word(32'h5555_5555);
    offer_word(32'hAAAA_AAAA);
    drain_results();

    run_phase(205, 0, 0);
    run_phase(205, 56, 0);
    run_phase(205, 0, 56);
    run_phase(205, 33, 33);

    // hold the output off while words keep coming, so the block backs up
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_reqs    <= hold_reqs + 1;
    repeat (30) offer_word(pick_seconds());
    drain_results();

    repeat (200) @(posedge clk);
    $display("%0d words checked: calendar landmarks, random epochs near day, year and",
             words_checked);
    $display("leap-February turns, four idle/stall mixes and one long output hold-off");
    if (mismatches == 0 && pending_words == 0) begin
      $display("epoch_seconds_to_calendar_top regression: pass");
    end else begin
      $display("epoch_seconds_to_calendar_top regression: fail");
    end
    $finish;
  end

endmodule
